@@ rtl/time_bucket_min_max_avg_defines.svh @@
// Assertion macros for the time bucket min/max/average block.
// Used by the port checker; depends on nothing else.
`ifndef TIME_BUCKET_MIN_MAX_AVG_DEFINES_SVH
`define TIME_BUCKET_MIN_MAX_AVG_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TBMMA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbmma check failed");

// Consequent must hold in the cycle after the antecedent
`define TBMMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbmma check failed");

`endif

@@ rtl/tbmma_pkg.sv @@
// Shared types and constants of the time bucket min/max/average block.
// No dependencies; used by the divider, queue, front, back, top level and bench.
`timescale 1ns / 1ps
`default_nettype none

package tbmma_pkg;

    // Fixed-point format and count saturation
    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 16;

    localparam logic [47:0] INT_SAT   = 48'((64'd1 << (47 - FRAC_BITS)) - 64'd1);
    localparam logic [15:0] COUNT_MAX = 16'((32'd1 << COUNT_BITS) - 32'd1);

    // Bucket length after reset, in seconds
    localparam logic [16:0] BUCKET_SECONDS_RESET = 17'd3600;

    // Divider step counts: 32 for the bucket number, 64 for the average
    localparam logic [6:0] DIV_STEPS_TIME = 7'd32;
    localparam logic [6:0] DIV_STEPS_AVG  = 7'd64;

    // Queue between front and back (depth is a power of two)
    localparam int FIFO_AW    = 1;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // Classified sample as it travels from front to back
    typedef struct packed {
        logic [31:0]        sample_time;
        logic [31:0]        bucket_num;
        logic signed [47:0] value;
        logic               is_last;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FLUSH_DIV,
        B_FLUSH_OUT,
        B_ACCUM,
        B_LAST_GO,
        B_LAST_DIV,
        B_LAST_OUT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/tbmma_if.sv @@
// Channel interfaces: sample input, trend result output, configuration write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tbmma_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        sample_time;
    logic               value_kind;
    logic signed [47:0] sample_value;
    logic               is_last;

    modport source (output valid, sample_time, value_kind, sample_value, is_last,
                    input ready);
    modport sink   (input valid, sample_time, value_kind, sample_value, is_last,
                    output ready);
endinterface

interface tbmma_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        trend_time;
    logic signed [47:0] trend_min;
    logic signed [47:0] trend_max;
    logic signed [47:0] trend_avg;
    logic [15:0]        sample_count;
    logic               last_of_run;

    modport source (output valid, trend_time, trend_min, trend_max, trend_avg,
                    sample_count, last_of_run, input ready);
    modport sink   (input valid, trend_time, trend_min, trend_max, trend_avg,
                    sample_count, last_of_run, output ready);
endinterface

interface tbmma_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] bucket_seconds;

    modport source (output valid, bucket_seconds, input ready);
    modport sink   (input valid, bucket_seconds, output ready);
endinterface

`default_nettype wire

@@ rtl/tbmma_div.sv @@
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 17-bit divisor.
// Depends on tbmma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbmma_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           dividend,
    input  logic [16:0]           divisor,
    input  logic [6:0]            steps,
    output tbmma_pkg::div_stat_t  stat,
    output logic [63:0]           quotient
);

    logic [63:0] acc_reg, acc_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [17:0] rem_sh;
    logic        ge;

    // One shift-subtract step; quotient bits enter acc at the bottom
    always_comb
    begin
        rem_sh    = {rem_reg, acc_reg[63]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            acc_next = {acc_reg[62:0], ge};
            rem_next = ge ? 17'(rem_sh - {1'b0, dvs_reg}) : rem_sh[16:0];
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            acc_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = acc_reg;

endmodule

`default_nettype wire

@@ rtl/tbmma_fifo.sv @@
// Two-entry queue of classified samples between front and back.
// Depends on tbmma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbmma_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tbmma_pkg::entry_t     push_data,
    input  logic                  pop,
    output tbmma_pkg::entry_t     pop_data,
    output tbmma_pkg::fifo_stat_t stat
);

    tbmma_pkg::entry_t mem [tbmma_pkg::FIFO_DEPTH];

    logic [tbmma_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tbmma_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tbmma_pkg::FIFO_AW:0]   cnt_reg, cnt_next;

    logic do_push;
    logic do_pop;

    assign stat.full  = cnt_reg == (tbmma_pkg::FIFO_AW + 1)'(tbmma_pkg::FIFO_DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    // Pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    assign pop_data = mem[rd_ptr_reg];

endmodule

`default_nettype wire

@@ rtl/tbmma_front.sv @@
// Front part: accepts samples, scales integer values to Q31.16 and finds the bucket number.
// Depends on tbmma_pkg, tbmma_if and tbmma_div.
`timescale 1ns / 1ps
`default_nettype none

module tbmma_front (
    input  logic                  clk,
    input  logic                  rst_n,
    tbmma_in_if.sink              sample,
    input  logic [16:0]           bucket_len,
    input  tbmma_pkg::fifo_stat_t fifo_stat,
    output logic                  push,
    output tbmma_pkg::entry_t     push_data
);

    tbmma_pkg::front_state_t state_reg, state_next;
    tbmma_pkg::entry_t       hold_reg, hold_next;

    tbmma_pkg::div_stat_t div_stat;
    logic [63:0]          div_quot;
    logic                 div_start;

    logic [47:0]        raw;
    logic [47:0]        u_sat;
    logic signed [47:0] value_conv;

    // Integer samples saturate, then shift into the fixed-point format
    always_comb
    begin
        raw        = sample.sample_value;
        u_sat      = (raw > tbmma_pkg::INT_SAT) ? tbmma_pkg::INT_SAT : raw;
        value_conv = sample.value_kind ? sample.sample_value
                                       : signed'(u_sat << tbmma_pkg::FRAC_BITS);
    end

    assign sample.ready = (state_reg == tbmma_pkg::F_IDLE) && !div_stat.busy;

    // Accept, divide, hand over to the queue
    always_comb
    begin
        state_next = state_reg;
        hold_next  = hold_reg;
        div_start  = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            tbmma_pkg::F_IDLE:
            begin
                if (sample.valid && sample.ready)
                begin
                    hold_next.sample_time = sample.sample_time;
                    hold_next.bucket_num  = '0;
                    hold_next.value       = value_conv;
                    hold_next.is_last     = sample.is_last;
                    div_start             = 1'b1;
                    state_next            = tbmma_pkg::F_DIV;
                end
            end
            tbmma_pkg::F_DIV:
            begin
                if (div_stat.done)
                begin
                    hold_next.bucket_num = div_quot[31:0];
                    state_next           = tbmma_pkg::F_PUSH;
                end
            end
            tbmma_pkg::F_PUSH:
            begin
                if (!fifo_stat.full)
                begin
                    push       = 1'b1;
                    state_next = tbmma_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = tbmma_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tbmma_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign push_data = hold_reg;

    // Bucket number = time / length; time loaded in the top half for 32 steps
    tbmma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sample.sample_time, 32'd0}),
        .divisor  (bucket_len),
        .steps    (tbmma_pkg::DIV_STEPS_TIME),
        .stat     (div_stat),
        .quotient (div_quot)
    );

endmodule

`default_nettype wire

@@ rtl/tbmma_back.sv @@
// Back part: keeps the open bucket, emits finished buckets with their average.
// Depends on tbmma_pkg, tbmma_if and tbmma_div.
`timescale 1ns / 1ps
`default_nettype none

module tbmma_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbmma_pkg::fifo_stat_t fifo_stat,
    input  tbmma_pkg::entry_t     head,
    output logic                  pop,
    tbmma_out_if.source           trend
);

    tbmma_pkg::back_state_t state_reg, state_next;
    tbmma_pkg::entry_t      cur_reg, cur_next;

    // Open bucket
    logic               open_reg, open_next;
    logic [31:0]        first_time_reg, first_time_next;
    logic [31:0]        number_reg, number_next;
    logic signed [47:0] min_reg, min_next;
    logic signed [47:0] max_reg, max_next;
    logic signed [63:0] sum_reg, sum_next;
    logic [15:0]        count_reg, count_next;
    logic signed [47:0] avg_reg, avg_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_time_reg, out_time_next;
    logic signed [47:0] out_min_reg, out_min_next;
    logic signed [47:0] out_max_reg, out_max_next;
    logic signed [47:0] out_avg_reg, out_avg_next;
    logic [15:0]        out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;

    tbmma_pkg::div_stat_t div_stat;
    logic [63:0]          div_quot;
    logic                 div_start;

    logic [63:0] sum_u;
    logic [63:0] sum_mag;
    logic [63:0] avg_full;
    logic        out_free;
    logic        load;
    logic        load_last;

    // Magnitude divide, sign restored afterwards (truncates toward zero)
    assign sum_u    = sum_reg;
    assign sum_mag  = sum_reg[63] ? (~sum_u + 64'd1) : sum_u;
    assign avg_full = sum_reg[63] ? (~div_quot + 64'd1) : div_quot;
    assign out_free = !out_valid_reg || trend.ready;

    // Bucket sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        open_next       = open_reg;
        first_time_next = first_time_reg;
        number_next     = number_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        avg_next        = avg_reg;
        pop             = 1'b0;
        div_start       = 1'b0;
        load            = 1'b0;
        load_last       = 1'b0;
        unique case (state_reg)
            tbmma_pkg::B_IDLE:
            begin
                if (!fifo_stat.empty && !div_stat.busy)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    if (open_reg && (head.bucket_num != number_reg))
                    begin
                        div_start  = 1'b1;
                        state_next = tbmma_pkg::B_FLUSH_DIV;
                    end
                    else
                    begin
                        state_next = tbmma_pkg::B_ACCUM;
                    end
                end
            end
            tbmma_pkg::B_FLUSH_DIV:
            begin
                if (div_stat.done)
                begin
                    avg_next   = avg_full[47:0];
                    state_next = tbmma_pkg::B_FLUSH_OUT;
                end
            end
            tbmma_pkg::B_FLUSH_OUT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_last  = !cur_reg.is_last;
                    open_next  = 1'b0;
                    state_next = tbmma_pkg::B_ACCUM;
                end
            end
            tbmma_pkg::B_ACCUM:
            begin
                if (!open_reg)
                begin
                    open_next       = 1'b1;
                    first_time_next = cur_reg.sample_time;
                    number_next     = cur_reg.bucket_num;
                    min_next        = cur_reg.value;
                    max_next        = cur_reg.value;
                    sum_next        = 64'(cur_reg.value);
                    count_next      = 16'd1;
                end
                else
                begin
                    if (cur_reg.value < min_reg)
                        min_next = cur_reg.value;
                    if (cur_reg.value > max_reg)
                        max_next = cur_reg.value;
                    // full count: only min and max move
                    if (count_reg < tbmma_pkg::COUNT_MAX)
                    begin
                        sum_next   = sum_reg + 64'(cur_reg.value);
                        count_next = count_reg + 16'd1;
                    end
                end
                state_next = cur_reg.is_last ? tbmma_pkg::B_LAST_GO : tbmma_pkg::B_IDLE;
            end
            tbmma_pkg::B_LAST_GO:
            begin
                div_start  = 1'b1;
                state_next = tbmma_pkg::B_LAST_DIV;
            end
            tbmma_pkg::B_LAST_DIV:
            begin
                if (div_stat.done)
                begin
                    avg_next   = avg_full[47:0];
                    state_next = tbmma_pkg::B_LAST_OUT;
                end
            end
            tbmma_pkg::B_LAST_OUT:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    load_last       = 1'b1;
                    open_next       = 1'b0;
                    first_time_next = '0;
                    number_next     = '0;
                    min_next        = '0;
                    max_next        = '0;
                    sum_next        = '0;
                    count_next      = '0;
                    state_next      = tbmma_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = tbmma_pkg::B_IDLE;
            end
        endcase
    end

    // Output register: holds a result until the request is taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !trend.ready;
        out_time_next  = out_time_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        out_avg_next   = out_avg_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_time_next  = first_time_reg;
            out_min_next   = min_reg;
            out_max_next   = max_reg;
            out_avg_next   = avg_reg;
            out_count_next = count_reg;
            out_last_next  = load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tbmma_pkg::B_IDLE;
            open_reg       <= 1'b0;
            first_time_reg <= '0;
            number_reg     <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            open_reg       <= open_next;
            first_time_reg <= first_time_next;
            number_reg     <= number_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        avg_reg       <= avg_next;
        out_time_reg  <= out_time_next;
        out_min_reg   <= out_min_next;
        out_max_reg   <= out_max_next;
        out_avg_reg   <= out_avg_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign trend.valid        = out_valid_reg;
    assign trend.trend_time   = out_time_reg;
    assign trend.trend_min    = out_min_reg;
    assign trend.trend_max    = out_max_reg;
    assign trend.trend_avg    = out_avg_reg;
    assign trend.sample_count = out_count_reg;
    assign trend.last_of_run  = out_last_reg;

    // Average = |sum| / count over 64 steps
    tbmma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  ({1'b0, count_reg}),
        .steps    (tbmma_pkg::DIV_STEPS_AVG),
        .stat     (div_stat),
        .quotient (div_quot)
    );

endmodule

`default_nettype wire

@@ rtl/time_bucket_min_max_avg.sv @@
// Top level of the tumbling-window min / max / average block; depends on tbmma_pkg,
// tbmma_if, tbmma_front, tbmma_fifo and tbmma_back.
// Front: takes no new sample until its 32-step bucket-number divide is done and the entry is
// queued. Back: one queued sample at a time, plus a flush with the 64-step average divide on
// a bucket change or a last sample; a bucket change with a last sample gives a second result
// after a second divide. Stalls add. Reset: bucket closed, state zero, bucket length 3600.
`timescale 1ns / 1ps
`default_nettype none

module time_bucket_min_max_avg (
    input  logic         clk,
    input  logic         rst_n,
    tbmma_cfg_if.sink    cfg,
    tbmma_in_if.sink     sample,
    tbmma_out_if.source  trend
);

    logic [16:0] bucket_seconds_reg, bucket_seconds_next;
    logic [16:0] bucket_len;

    tbmma_pkg::fifo_stat_t fifo_stat;
    tbmma_pkg::entry_t     push_data;
    tbmma_pkg::entry_t     head;
    logic                  push;
    logic                  pop;

    // Bucket length register; a length of zero acts as one
    assign cfg.ready           = 1'b1;
    assign bucket_seconds_next = cfg.valid ? cfg.bucket_seconds : bucket_seconds_reg;
    assign bucket_len          = (bucket_seconds_reg == '0) ? 17'd1 : bucket_seconds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_seconds_reg <= tbmma_pkg::BUCKET_SECONDS_RESET;
        else
            bucket_seconds_reg <= bucket_seconds_next;
    end

    tbmma_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .bucket_len (bucket_len),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_data  (push_data)
    );

    tbmma_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .stat      (fifo_stat)
    );

    tbmma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .head      (head),
        .pop       (pop),
        .trend     (trend)
    );

endmodule

`default_nettype wire

@@ rtl/tbmma_checker.sv @@
// Port checker for the time bucket block, bound to the top level.
// Depends on time_bucket_min_max_avg_defines.svh and time_bucket_min_max_avg.
`timescale 1ns / 1ps
`default_nettype none
`include "time_bucket_min_max_avg_defines.svh"

module tbmma_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               trend_valid,
    input logic               trend_ready,
    input logic signed [47:0] trend_min,
    input logic signed [47:0] trend_max,
    input logic signed [47:0] trend_avg,
    input logic [15:0]        sample_count
);

    // A pending request stays up until taken
    `TBMMA_ASSERT_NEXT(a_out_hold, clk, rst_n, trend_valid && !trend_ready, trend_valid)

    // Every emitted bucket holds at least one sample
    `TBMMA_ASSERT_SAME(a_count_nonzero, clk, rst_n, trend_valid, sample_count != 16'd0)

    // Extremes are ordered
    `TBMMA_ASSERT_SAME(a_min_le_max, clk, rst_n, trend_valid, trend_min <= trend_max)

    // Average lies between the extremes
    `TBMMA_ASSERT_SAME(a_avg_in_range, clk, rst_n, trend_valid,
                       (trend_min <= trend_avg) && (trend_avg <= trend_max))

endmodule

bind time_bucket_min_max_avg tbmma_checker u_tbmma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .trend_valid  (trend.valid),
    .trend_ready  (trend.ready),
    .trend_min    (trend.trend_min),
    .trend_max    (trend.trend_max),
    .trend_avg    (trend.trend_avg),
    .sample_count (trend.sample_count)
);

`default_nettype wire

@@ bench/time_bucket_min_max_avg_tb.sv @@
// Self-checking bench for the tumbling-window min / max / average block.
// Depends on tbmma_pkg, the channel interfaces in tbmma_if and the block's RTL.
`timescale 1ns / 1ps

module time_bucket_min_max_avg_tb;

    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 8;
    // Settle time for zero-result samples still in flight after the last result
    localparam int          SETTLE_CYCLES  = 300;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          PHASE_ITEMS    = 190;
    localparam int          IDLE_PERCENT   = 36;
    localparam logic        KIND_INT       = 1'b0;
    localparam logic        KIND_FIXED     = 1'b1;
    localparam logic [16:0] LEN_MAX        = 17'h1FFFF;

    typedef struct packed {
        logic [31:0]        sample_time;
        logic               value_kind;
        logic signed [47:0] sample_value;
        logic               is_last;
    } sample_t;

    typedef struct packed {
        logic [31:0]        trend_time;
        logic signed [47:0] trend_min;
        logic signed [47:0] trend_max;
        logic signed [47:0] trend_avg;
        logic [15:0]        sample_count;
        logic               last_of_run;
    } trend_t;

    // Bucket tracker and queue of trend results still owed by the block
    class trend_scoreboard;
        logic [16:0]        bucket_seconds;
        bit                 open;
        logic [31:0]        first_time;
        logic [31:0]        bucket_num;
        logic signed [63:0] run_min;
        logic signed [63:0] run_max;
        logic signed [63:0] run_sum;
        logic [15:0]        run_count;
        trend_t             pending[$];
        int                 errors;

        function new();
            bucket_seconds = tbmma_pkg::BUCKET_SECONDS_RESET;
            errors = 0;
            clear_bucket();
        endfunction

        function void clear_bucket();
            open = 0;
            first_time = '0;
            bucket_num = '0;
            run_min = '0;
            run_max = '0;
            run_sum = '0;
            run_count = '0;
        endfunction

        function void set_length(logic [16:0] len);
            bucket_seconds = len;
        endfunction

        // Close out the open bucket into one expected result
        function void emit(bit last);
            trend_t             r;
            logic signed [63:0] divisor;
            logic signed [63:0] avg;
            divisor = {48'd0, run_count};
            avg = (run_count != 0) ? run_sum / divisor : 64'sd0;
            r.trend_time   = first_time;
            r.trend_min    = run_min[47:0];
            r.trend_max    = run_max[47:0];
            r.trend_avg    = avg[47:0];
            r.sample_count = run_count;
            r.last_of_run  = last;
            pending.push_back(r);
        endfunction

        // Accepted sample request: update the bucket, queue what it flushes
        function void note_sample(sample_t s);
            logic [31:0]        span;
            logic [31:0]        bnum;
            logic [47:0]        mag;
            logic signed [63:0] v;
            span = (bucket_seconds == 0) ? 32'd1 : {15'd0, bucket_seconds};
            bnum = s.sample_time / span;
            if (s.value_kind == KIND_FIXED)
            begin
                v = {{16{s.sample_value[47]}}, s.sample_value};
            end
            else
            begin
                mag = s.sample_value;
                if (mag > tbmma_pkg::INT_SAT)
                    mag = tbmma_pkg::INT_SAT;
                v = {16'd0, mag} << tbmma_pkg::FRAC_BITS;
            end

            if (open && bnum != bucket_num)
            begin
                emit(!s.is_last);
                open = 0;
            end

            if (!open)
            begin
                open = 1;
                first_time = s.sample_time;
                bucket_num = bnum;
                run_min = v;
                run_max = v;
                run_sum = v;
                run_count = 16'd1;
            end
            else
            begin
                if (v < run_min)
                    run_min = v;
                if (v > run_max)
                    run_max = v;
                if (run_count < tbmma_pkg::COUNT_MAX)
                begin
                    run_sum += v;
                    run_count++;
                end
            end

            if (s.is_last)
            begin
                emit(1'b1);
                clear_bucket();
            end
        endfunction

        // Accepted trend result: compare with the oldest one owed
        function void check_trend(trend_t got);
            trend_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected trend result at time %0d", got.trend_time);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.trend_time !== want.trend_time)
            begin
                $error("trend_time: expected %0d, got %0d", want.trend_time, got.trend_time);
                errors++;
            end
            if (got.trend_min !== want.trend_min)
            begin
                $error("trend_min: expected %0d, got %0d", want.trend_min, got.trend_min);
                errors++;
            end
            if (got.trend_max !== want.trend_max)
            begin
                $error("trend_max: expected %0d, got %0d", want.trend_max, got.trend_max);
                errors++;
            end
            if (got.trend_avg !== want.trend_avg)
            begin
                $error("trend_avg: expected %0d, got %0d", want.trend_avg, got.trend_avg);
                errors++;
            end
            if (got.sample_count !== want.sample_count)
            begin
                $error("sample_count: expected %0d, got %0d",
                       want.sample_count, got.sample_count);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0d, got %0d",
                       want.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int unsigned quiet_cycles;

    trend_scoreboard sb = new();

    tbmma_cfg_if cfg_if();
    tbmma_in_if  sample_if();
    tbmma_out_if trend_if();

    time_bucket_min_max_avg dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .sample (sample_if),
        .trend  (trend_if)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        trend_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Check every accepted result request
    always @(posedge clk)
    begin
        if (rst_n && trend_if.valid && trend_if.ready)
            sb.check_trend('{trend_if.trend_time, trend_if.trend_min, trend_if.trend_max,
                             trend_if.trend_avg, trend_if.sample_count,
                             trend_if.last_of_run});
    end

    // Watchdog: too long with no request moving on any channel
    always @(posedge clk)
    begin
        if ((sample_if.valid && sample_if.ready) || (trend_if.valid && trend_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // All drive tasks start and end at a falling edge
    task automatic send_sample(logic [31:0] t, logic kind, logic [47:0] val, logic last);
        sample_t s;
        s = '{t, kind, val, last};
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_if.valid <= 1'b0;
            @(negedge clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.sample_time  <= s.sample_time;
        sample_if.value_kind   <= s.value_kind;
        sample_if.sample_value <= s.sample_value;
        sample_if.is_last      <= s.is_last;
        do
            @(posedge clk);
        while (!sample_if.ready);
        sb.note_sample(s);
        @(negedge clk);
    endtask

    task automatic set_length(logic [16:0] len);
        cfg_if.valid          <= 1'b1;
        cfg_if.bucket_seconds <= len;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.set_length(len);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Drain owed results, then let zero-result samples clear the pipeline
    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly forward steps inside a bucket, some jumps and some backwards
    function automatic logic [31:0] next_time(logic [31:0] cur, int unsigned span);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return cur + $urandom_range(0, span / 3 + 1);
        else if (pick < 85)
            return cur + span * $urandom_range(1, 3);
        else if (pick < 93)
            return cur - $urandom_range(0, span);
        else
            return $urandom;
    endfunction

    function automatic logic [47:0] rand_value();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return wide[47:0];
            1: return 48'($urandom_range(0, 2000));
            2: return -48'($urandom_range(1, 2000));
            3:
                case ($urandom_range(3))
                    0:       return 48'h0;
                    1:       return 48'h7FFF_FFFF_FFFF;
                    2:       return 48'h8000_0000_0000;
                    default: return 48'hFFFF_FFFF_FFFF;
                endcase
            4: return 48'h7FFF_FFF0 + 48'($urandom_range(0, 31));
            default: return {16'h0, wide[31:0]};
        endcase
    endfunction

    initial
    begin
        logic [16:0] lengths[7];
        logic [31:0] t;
        int unsigned span;

        rst_n = 1'b0;
        steady = 0;
        quiet_cycles = 0;
        cfg_if.valid = 1'b0;
        cfg_if.bucket_seconds = '0;
        sample_if.valid = 1'b0;
        sample_if.sample_time = '0;
        sample_if.value_kind = KIND_INT;
        sample_if.sample_value = '0;
        sample_if.is_last = 1'b0;
        trend_if.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, saturation, flush paths at the reset length
        send_sample(32'd0,     KIND_INT,   48'd0,             1'b0);
        send_sample(32'd100,   KIND_INT,   48'hFFFF_FFFF_FFFF, 1'b0);
        send_sample(32'd3599,  KIND_FIXED, 48'h8000_0000_0000, 1'b0);
        send_sample(32'd3600,  KIND_FIXED, 48'h7FFF_FFFF_FFFF, 1'b0);
        send_sample(32'd3700,  KIND_INT,   48'h0000_7FFF_FFFF, 1'b1);
        send_sample(32'd7200,  KIND_FIXED, 48'd1,             1'b1);
        send_sample(32'd10000, KIND_FIXED, -48'd3,            1'b0);
        send_sample(32'd10001, KIND_FIXED, -48'd4,            1'b0);
        // bucket change and last together: two results
        send_sample(32'd20000, KIND_INT,   48'h0000_8000_0000, 1'b1);
        // time going backwards
        send_sample(32'd50000, KIND_FIXED, 48'd5,             1'b0);
        send_sample(32'd40000, KIND_FIXED, 48'd7,             1'b0);
        send_sample(32'hFFFF_FFFF, KIND_FIXED, 48'hFFFF_FFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, KIND_INT,   48'h5555_5555_5555, 1'b0);
        // zero length while a bucket is open
        wait_idle();
        set_length(17'd0);
        send_sample(32'hFFFF_FFFF, KIND_FIXED, 48'hAAAA_AAAA_AAAA, 1'b0);
        send_sample(32'hFFFF_FFFF, KIND_FIXED, 48'd3,             1'b0);
        send_sample(32'd0,         KIND_INT,   48'h2AAA_AAAA_AAAA, 1'b1);
        wait_idle();
        set_length(17'd1);
        send_sample(32'd5, KIND_INT,   48'd9,  1'b0);
        send_sample(32'd5, KIND_FIXED, -48'd9, 1'b0);
        send_sample(32'd6, KIND_INT,   48'd1,  1'b1);
        wait_idle();
        set_length(LEN_MAX);
        send_sample(32'd0,      KIND_FIXED, -48'd1, 1'b0);
        send_sample(32'd131070, KIND_FIXED, 48'd2,  1'b0);
        send_sample(32'd131071, KIND_FIXED, 48'd4,  1'b1);

        // Random phases, one bucket length each; open buckets carry across
        lengths[0] = 17'($urandom_range(2, 50));
        lengths[1] = 17'd1;
        lengths[2] = 17'd0;
        lengths[3] = 17'd86400;
        lengths[4] = LEN_MAX;
        lengths[5] = tbmma_pkg::BUCKET_SECONDS_RESET;
        lengths[6] = 17'($urandom_range(1, 86400));
        t = $urandom;
        for (int p = 0; p < 7; p++)
        begin
            wait_idle();
            set_length(lengths[p]);
            steady = (p == 4);
            span = (lengths[p] == 0) ? 1 : lengths[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                t = next_time(t, span);
                send_sample(t, 1'($urandom_range(1)), rand_value(),
                            ($urandom_range(99) < 5));
            end
        end
        steady = 0;

        // Drain and report
        wait_idle();
        if (sb.pending.size() != 0)
        begin
            $error("%0d trend results never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
